### rtl/core/assert_macros.svh
// Assertion macros shared by the lexer RTL.
// Depends on clk and rst_n being visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/cll_pkg.sv
// Types, token codes and byte classes for the configuration line lexer.
// No dependencies.
package cll_pkg;

  localparam int CLL_MAX_TOKENS = 3;
  localparam int CLL_QUEUE_DEPTH = 4;

  localparam logic [3:0] KIND_CHAR  = 4'd0;
  localparam logic [3:0] KIND_IDEND = 4'd1;
  localparam logic [3:0] KIND_ENDL  = 4'd2;
  localparam logic [3:0] KIND_DOT   = 4'd3;
  localparam logic [3:0] KIND_EQUAL = 4'd4;
  localparam logic [3:0] KIND_LBRK  = 4'd5;
  localparam logic [3:0] KIND_RBRK  = 4'd6;
  localparam logic [3:0] KIND_LPAR  = 4'd7;
  localparam logic [3:0] KIND_RPAR  = 4'd8;
  localparam logic [3:0] KIND_COMMA = 4'd9;
  localparam logic [3:0] KIND_COLON = 4'd10;
  localparam logic [3:0] KIND_SLASH = 4'd11;
  localparam logic [3:0] KIND_NONE  = 4'd15;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_end;
  } in_word_t;

  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] char_out;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] ch;
  } token_t;

  typedef struct packed {
    logic [1:0]                         count;
    token_t [CLL_MAX_TOKENS-1:0]        tok;
  } entry_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
           (c >= CH_LA && c <= CH_LZ) || c == CH_USCORE || c == CH_MINUS ||
           c == CH_PLUS || c == CH_QMARK;
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    logic [3:0] k;
    unique case (c)
      CH_NL:    k = KIND_ENDL;
      CH_DOT:   k = KIND_DOT;
      CH_EQUAL: k = KIND_EQUAL;
      CH_LBRK:  k = KIND_LBRK;
      CH_RBRK:  k = KIND_RBRK;
      CH_LPAR:  k = KIND_LPAR;
      CH_RPAR:  k = KIND_RPAR;
      CH_COMMA: k = KIND_COMMA;
      CH_COLON: k = KIND_COLON;
      CH_SLASH: k = KIND_SLASH;
      default:  k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

### rtl/core/config_line_lexer.sv
// Configuration line lexer: one byte per word in, one token per word out.
// Tokens of a byte pass through the entry queue and then the registered output stage.
// Throughput: one byte per cycle while the queue is not full and each byte
// yields at most one token; a byte yielding k tokens holds the output port for k
// words, and QUEUE_DEPTH entries of buffering keep input taking bytes meanwhile.
// Reset (synchronous, rst_n low): clears lexer state, queue and output valid.
`include "assert_macros.svh"

module config_line_lexer #(
  parameter int QUEUE_DEPTH = cll_pkg::CLL_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cll_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output cll_pkg::out_word_t out_word
);
  import cll_pkg::*;

  logic    push, pop;
  entry_t  push_entry, head_entry;
  q_stat_t q_stat;

  assign in_ready = !q_stat.full;

  cll_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .push       (push),
    .push_entry (push_entry)
  );

  cll_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .stat       (q_stat)
  );

  cll_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_entry (head_entry),
    .stat       (q_stat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

  `ASSERT_CLK(a_push_not_full, push |-> !q_stat.full, "push into full queue")
  `ASSERT_CLK(a_pop_not_empty, pop |-> q_stat.not_empty, "pop from empty queue")
  `ASSERT_CLK(a_line_end_pushes, (in_valid && in_ready && in_word.line_end) |-> (push && (push_entry.count != 2'd0)), "line end gave no tokens")
  `ASSERT_CLK(a_char_zero, (out_valid && out_word.token_kind != KIND_CHAR) |-> (out_word.char_out == 8'd0), "non-char token carries a byte")

endmodule

### rtl/core/cll_front.sv
// Front end: accepts bytes, tracks quote/escape/identifier/comment state
// and packs the tokens of each byte into one queue entry. Uses cll_pkg.
module cll_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  cll_pkg::in_word_t in_word,
  output logic              push,
  output cll_pkg::entry_t   push_entry
);
  import cll_pkg::*;

  logic quote_r, esc_r, chars_r, skip_r;
  logic quote_nxt, esc_nxt, chars_nxt, skip_nxt;
  logic accept;

  token_t     toks [4];
  logic [1:0] n;
  logic [7:0] c;
  logic       ident;
  logic [3:0] pk;

  assign accept = in_valid && in_ready;

  always_comb begin
    c         = in_word.char_in;
    ident     = is_ident(c);
    pk        = punct_kind(c);
    quote_nxt = quote_r;
    esc_nxt   = esc_r;
    chars_nxt = chars_r;
    skip_nxt  = skip_r;
    n         = 2'd0;
    for (int i = 0; i < 4; i++) begin
      toks[i] = '0;
    end

    if (skip_r) begin
    end else if (quote_r) begin
      if (esc_r && (c == CH_QUOTE || c == CH_BSLASH)) begin
        toks[n]   = '{kind: KIND_CHAR, ch: c};
        n         = n + 2'd1;
        chars_nxt = 1'b1;
        esc_nxt   = 1'b0;
      end else if (c == CH_BSLASH && !esc_r) begin
        esc_nxt = 1'b1;
      end else if (c == CH_QUOTE && !esc_r) begin
        quote_nxt = 1'b0;
        toks[n]   = '{kind: KIND_IDEND, ch: 8'd0};
        n         = n + 2'd1;
        chars_nxt = 1'b0;
      end else begin
        toks[n]   = '{kind: KIND_CHAR, ch: c};
        n         = n + 2'd1;
        chars_nxt = 1'b1;
      end
    end else if (!chars_r && c == CH_QUOTE) begin
      quote_nxt = 1'b1;
    end else begin
      if (!ident && chars_r) begin
        toks[n]   = '{kind: KIND_IDEND, ch: 8'd0};
        n         = n + 2'd1;
        chars_nxt = 1'b0;
      end
      if (c == CH_HASH) begin
        skip_nxt = 1'b1;
      end else begin
        if (pk != KIND_NONE) begin
          toks[n] = '{kind: pk, ch: 8'd0};
          n       = n + 2'd1;
        end
        if (ident) begin
          toks[n]   = '{kind: KIND_CHAR, ch: c};
          n         = n + 2'd1;
          chars_nxt = 1'b1;
        end
      end
    end

    if (in_word.line_end) begin
      if (chars_nxt) begin
        toks[n] = '{kind: KIND_IDEND, ch: 8'd0};
        n       = n + 2'd1;
      end
      toks[n]   = '{kind: KIND_ENDL, ch: 8'd0};
      n         = n + 2'd1;
      quote_nxt = 1'b0;
      esc_nxt   = 1'b0;
      chars_nxt = 1'b0;
      skip_nxt  = 1'b0;
    end
  end

  always_comb begin
    push_entry.count = n;
    for (int i = 0; i < CLL_MAX_TOKENS; i++) begin
      push_entry.tok[i] = toks[i];
    end
  end

  assign push = accept && (n != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_r <= 1'b0;
      esc_r   <= 1'b0;
      chars_r <= 1'b0;
      skip_r  <= 1'b0;
    end else if (accept) begin
      quote_r <= quote_nxt;
      esc_r   <= esc_nxt;
      chars_r <= chars_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule

### rtl/core/cll_queue.sv
// Small entry queue between the lexer front end and the token serializer.
// Uses cll_pkg for the entry and status types.
module cll_queue #(
  parameter int DEPTH = cll_pkg::CLL_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cll_pkg::entry_t push_entry,
  input  logic            pop,
  output cll_pkg::entry_t head_entry,
  output cll_pkg::q_stat_t stat
);
  import cll_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.not_empty = (cnt_r != '0);
  assign stat.full      = (cnt_r == FULL_CNT);
  assign head_entry     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### rtl/core/cll_back.sv
// Back end: walks the tokens of the head queue entry, one output word per
// cycle while out_ready allows, into a registered output stage. Uses cll_pkg.
module cll_back (
  input  logic              clk,
  input  logic              rst_n,
  input  cll_pkg::entry_t   head_entry,
  input  cll_pkg::q_stat_t  stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output cll_pkg::out_word_t out_word
);
  import cll_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r;
  out_word_t  out_word_r;
  logic       load;
  logic       last_tok;
  token_t     cur;

  assign load     = stat.not_empty && (!out_valid_r || out_ready);
  assign last_tok = ((idx_r + 2'd1) == head_entry.count);
  assign pop      = load && last_tok;

  always_comb begin
    unique case (idx_r)
      2'd0:    cur = head_entry.tok[0];
      2'd1:    cur = head_entry.tok[1];
      default: cur = head_entry.tok[2];
    endcase
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = last_tok ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r <= '{token_kind: cur.kind, char_out: cur.ch, last_of_run: last_tok};
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### tb/config_line_lexer_tb.sv
// Self-checking testbench for config_line_lexer: directed and random lines of
// bytes, each predicted token compared with what the block sends out.
// Depends on cll_pkg and the config_line_lexer RTL.
module config_line_lexer_tb;
  import cll_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 20;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;

  logic in_fire = 1'b0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int words_queued = 0;
  int words_taken = 0;
  int errors = 0;
  int cycle_count = 0;

  in_word_t byte_queue[$];
  out_word_t expected_tokens[$];
  out_word_t run_toks[3];
  int run_n;
  out_word_t want_tok;

  logic quoted = 1'b0;
  logic escaped = 1'b0;
  logic id_open = 1'b0;
  logic skipping = 1'b0;

  logic [7:0] punct_set[10] = '{CH_DOT, CH_EQUAL, CH_LBRK, CH_RBRK, CH_LPAR, CH_RPAR,
                                CH_COMMA, CH_COLON, CH_SLASH, CH_NL};
  int idle_table[4] = '{0, 70, 0, 9};
  int stall_table[4] = '{0, 0, 70, 9};

  config_line_lexer i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic ident_byte(input logic [7:0] c);
    return c inside {[CH_0:CH_9], [CH_UA:CH_UZ], [CH_LA:CH_LZ], CH_USCORE, CH_MINUS,
                     CH_PLUS, CH_QMARK};
  endfunction

  function automatic logic [3:0] punct_code(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      CH_NL: k = KIND_ENDL;
      CH_DOT: k = KIND_DOT;
      CH_EQUAL: k = KIND_EQUAL;
      CH_LBRK: k = KIND_LBRK;
      CH_RBRK: k = KIND_RBRK;
      CH_LPAR: k = KIND_LPAR;
      CH_RPAR: k = KIND_RPAR;
      CH_COMMA: k = KIND_COMMA;
      CH_COLON: k = KIND_COLON;
      CH_SLASH: k = KIND_SLASH;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  task automatic add_token(input logic [3:0] kind, input logic [7:0] ch);
    if (run_n < 3) begin
      run_toks[run_n].token_kind = kind;
      run_toks[run_n].char_out = (kind == KIND_CHAR) ? ch : 8'h00;
      run_toks[run_n].last_of_run = 1'b0;
      run_n++;
    end
  endtask

  task automatic lex_byte(input in_word_t w);
    logic [7:0] c;
    logic ident;
    logic [3:0] pk;
    c = w.char_in;
    run_n = 0;
    if (skipping) begin
    end else if (quoted) begin
      if (escaped && (c == CH_QUOTE || c == CH_BSLASH)) begin
        add_token(KIND_CHAR, c);
        id_open = 1'b1;
        escaped = 1'b0;
      end else if (c == CH_BSLASH) begin
        escaped = 1'b1;
      end else if (c == CH_QUOTE) begin
        quoted = 1'b0;
        add_token(KIND_IDEND, 8'h00);
        id_open = 1'b0;
      end else begin
        add_token(KIND_CHAR, c);
        id_open = 1'b1;
      end
    end else if (!id_open && c == CH_QUOTE) begin
      quoted = 1'b1;
    end else begin
      ident = ident_byte(c);
      if (!ident && id_open) begin
        add_token(KIND_IDEND, 8'h00);
        id_open = 1'b0;
      end
      if (c == CH_HASH) begin
        skipping = 1'b1;
      end else begin
        pk = punct_code(c);
        if (pk != KIND_NONE) add_token(pk, 8'h00);
        if (ident) begin
          add_token(KIND_CHAR, c);
          id_open = 1'b1;
        end
      end
    end
    if (w.line_end) begin
      if (id_open) add_token(KIND_IDEND, 8'h00);
      add_token(KIND_ENDL, 8'h00);
      quoted = 1'b0;
      escaped = 1'b0;
      id_open = 1'b0;
      skipping = 1'b0;
    end
    for (int i = 0; i < run_n; i++) begin
      if (i == run_n - 1) run_toks[i].last_of_run = 1'b1;
      expected_tokens = {expected_tokens, run_toks[i]};
    end
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    errors++;
  endtask

  task automatic put_byte(input logic [7:0] c, input logic last);
    in_word_t w;
    w.char_in = c;
    w.line_end = last;
    byte_queue = {byte_queue, w};
    words_queued++;
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < 40) begin
      case ($urandom_range(4))
        0: c = CH_LA + 8'($urandom_range(25));
        1: c = CH_UA + 8'($urandom_range(25));
        2: c = CH_0 + 8'($urandom_range(9));
        3: c = $urandom_range(1) ? CH_USCORE : CH_MINUS;
        default: c = $urandom_range(1) ? CH_PLUS : CH_QMARK;
      endcase
    end else if (r < 60) begin
      c = punct_set[$urandom_range(9)];
    end else if (r < 70) begin
      c = CH_QUOTE;
    end else if (r < 78) begin
      c = CH_BSLASH;
    end else if (r < 82) begin
      c = CH_HASH;
    end else begin
      c = 8'($urandom_range(255));
    end
    return c;
  endfunction

  task automatic queue_line(input int len, input logic noisy);
    logic last;
    for (int i = 0; i < len; i++) begin
      last = (i == len - 1);
      if (noisy && $urandom_range(4) == 0) last = ~last;
      put_byte(pick_byte(), last);
    end
  endtask

  task automatic queue_directed();
    put_byte(CH_LZ, 1'b0);
    put_byte(CH_DOT, 1'b0);
    put_byte(CH_EQUAL, 1'b0);
    put_byte(CH_LBRK, 1'b0);
    put_byte(CH_RBRK, 1'b0);
    put_byte(CH_LPAR, 1'b0);
    put_byte(CH_RPAR, 1'b0);
    put_byte(CH_COMMA, 1'b0);
    put_byte(CH_COLON, 1'b0);
    put_byte(CH_SLASH, 1'b1);
    put_byte(CH_QUOTE, 1'b0);
    put_byte(CH_QUOTE, 1'b0);
    put_byte(CH_LA, 1'b0);
    put_byte(CH_QUOTE, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b1);
    put_byte(CH_QUOTE, 1'b0);
    put_byte(CH_BSLASH, 1'b0);
    put_byte(CH_UZ, 1'b0);
    put_byte(CH_QUOTE, 1'b0);
    put_byte(CH_9, 1'b1);
    put_byte(CH_UA, 1'b0);
    put_byte(CH_NL, 1'b1);
    put_byte(CH_0, 1'b0);
    put_byte(CH_HASH, 1'b0);
    put_byte(CH_QUOTE, 1'b0);
    put_byte(8'h7F, 1'b0);
    put_byte(8'h80, 1'b1);
  endtask

  // drive: present the next word once the previous one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (byte_queue.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_word <= byte_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    in_fire <= in_valid && in_ready && rst_n;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        lex_byte(in_word);
        words_taken <= words_taken + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          flag_mismatch("token with none pending, kind", out_word.token_kind, -1);
        end else begin
          want_tok = expected_tokens.pop_front();
          if (out_word.token_kind !== want_tok.token_kind)
            flag_mismatch("token_kind", out_word.token_kind, want_tok.token_kind);
          if (out_word.char_out !== want_tok.char_out)
            flag_mismatch("char_out", out_word.char_out, want_tok.char_out);
          if (out_word.last_of_run !== want_tok.last_of_run)
            flag_mismatch("last_of_run", out_word.last_of_run, want_tok.last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("config_line_lexer regression: fail");
      $finish;
    end
  end

  initial begin
    int start_count;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 4; p++) begin
      @(posedge clk);
      in_idle_pct = idle_table[p];
      out_stall_pct = stall_table[p];
      if (p == 0) queue_directed();
      start_count = words_queued;
      while (words_queued - start_count < RANDOM_PER_PHASE)
        queue_line($urandom_range(1, 12), $urandom_range(4) == 0);
      // wait until every queued byte is taken and every pending token has come out
      @(negedge clk);
      while (words_taken != words_queued || expected_tokens.size() != 0) @(negedge clk);
    end
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("config_line_lexer regression: pass");
    end else begin
      $display("config_line_lexer regression: fail");
    end
    $finish;
  end

endmodule
